@@ sv/hcbp_pkg.sv @@
// ============================================================================
// hcbp_pkg - shared types and constants for the Huffman code bit packer
// Item structs, opcodes and fixed field widths.
// ============================================================================
`default_nettype none

package hcbp_pkg;

    localparam int BYTE_W      = 8;    // output byte width
    localparam int PEND_W      = 7;    // max bits left over between items
    localparam int PCNT_W      = 3;    // pending bit count width
    localparam int SYM_W       = 8;    // symbol width
    localparam int CODE_W      = 32;   // code word width
    localparam int LEN_W       = 6;    // code length width
    localparam int TABLE_DEPTH = 256;  // one entry per byte value

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [SYM_W-1:0]    symbol;
        logic [CODE_W-1:0]   code_word;
        logic [LEN_W-1:0]    code_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   packed_byte;
        logic                last_of_run;
        logic                padded;
    } out_item_t;

endpackage

`default_nettype wire

@@ sv/huffman_code_bit_packer.sv @@
// ============================================================================
// huffman_code_bit_packer - Huffman encoder back end
// Code table plus MSB-first bit packer; one byte per cycle unless stalled.
// ============================================================================
// Usage:
//   in channel  (in_valid/in_ready/in_data): load, encode or flush items.
//     load   - writes code word and length of one symbol into the table.
//     encode - looks up the symbol's code and appends it to the bit stream.
//     flush  - emits any partial byte, zero padded in its low bits.
//   out channel (out_valid/out_ready/out_data): one packed byte per item,
//     last_of_run marks the final byte caused by an input item.
// Path: the table is read as an item is accepted, then the item is packed
//   into the output buffer, whose top byte drives out_data.
// Throughput: bytes leave one per cycle while out_ready is high; an item
//   makes n bytes, n at most (MAX_CODE_LEN + 7) / 8, the buffer depth.
//   Items that make no byte go at one per cycle while the buffer is free.
// Reset: all table entries read as absent (length zero) through per-entry
//   valid flags; no pending bits. Nothing is emitted out of reset.
// Stall: while out_ready is low the byte buffer holds; one item can wait in
//   the lookup stage, after which in_ready drops.
// ============================================================================
`default_nettype none

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcbp_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hcbp_pkg::out_item_t     out_data
);

    localparam int BYTE_W  = hcbp_pkg::BYTE_W;
    localparam int PEND_W  = hcbp_pkg::PEND_W;
    localparam int PCNT_W  = hcbp_pkg::PCNT_W;
    localparam int CODE_W  = hcbp_pkg::CODE_W;
    localparam int LEN_W   = hcbp_pkg::LEN_W;
    localparam int DEPTH   = hcbp_pkg::TABLE_DEPTH;
    localparam int ENT_W   = CODE_W + LEN_W;
    localparam int ACC_W   = MAX_CODE_LEN + PEND_W;
    localparam int MAX_RES = (MAX_CODE_LEN + PEND_W) / BYTE_W;
    localparam int BUF_W   = MAX_RES * BYTE_W;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int TOT_W   = LEN_W + 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_LEN);

    // ------------------------------------------------------------------
    // Accept and table write
    // ------------------------------------------------------------------
    logic                in_fire;
    logic                ld_we;
    logic [LEN_W-1:0]    ld_len;
    logic [CODE_W-1:0]   ld_mask;
    logic [ENT_W-1:0]    ld_entry;
    logic [ENT_W-1:0]    rd_entry;
    logic [LEN_W-1:0]    rd_len;
    logic [CODE_W-1:0]   rd_word;

    assign in_fire = in_valid && in_ready;
    assign ld_we   = in_fire && (in_data.opcode == hcbp_pkg::OP_LOAD);

    // saturate length, drop code bits above it
    assign ld_len  = (in_data.code_length > MAX_LEN) ? MAX_LEN : in_data.code_length;
    assign ld_mask = (ld_len >= LEN_W'(CODE_W)) ? {CODE_W{1'b1}}
                                                : ~({CODE_W{1'b1}} << ld_len);
    assign ld_entry = {ld_len, in_data.code_word & ld_mask};

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ld_we),
        .waddr (in_data.symbol),
        .wdata (ld_entry),
        .re    (in_fire),
        .raddr (in_data.symbol),
        .rdata (rd_entry)
    );

    assign rd_len  = rd_entry[ENT_W-1 -: LEN_W];
    assign rd_word = rd_entry[CODE_W-1:0];

    // entry written since reset; unwritten entries read as absent
    logic [DEPTH-1:0] hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else if (ld_we)
        begin
            hit_reg[in_data.symbol] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Lookup stage: item waits here while the table read completes
    // ------------------------------------------------------------------
    logic                a_vld_reg;
    logic                a_vld_next;
    hcbp_pkg::opcode_t   a_op_reg;
    logic                a_hit_reg;
    logic                b_fire;
    logic                buf_free;

    assign in_ready   = !a_vld_reg || b_fire;
    assign a_vld_next = in_fire ? 1'b1 : (b_fire ? 1'b0 : a_vld_reg);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_op_reg  <= in_data.opcode;
            a_hit_reg <= hit_reg[in_data.symbol];
        end
    end

    // ------------------------------------------------------------------
    // Pack stage: merge code with pending bits, split into bytes
    // ------------------------------------------------------------------
    logic [PEND_W-1:0]   pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0]   pend_cnt_reg,  pend_cnt_next;
    logic [BUF_W-1:0]    out_buf_reg,   out_buf_next;
    logic [CNT_W-1:0]    out_cnt_reg,   out_cnt_next;
    logic                out_pad_reg,   out_pad_next;

    logic [LEN_W-1:0]    clen;
    logic [ACC_W-1:0]    acc;
    logic [ACC_W-1:0]    acc_hi;
    logic [TOT_W-1:0]    total;
    logic [CNT_W-1:0]    nbytes;
    logic [PCNT_W-1:0]   rem;
    logic [BUF_W-1:0]    enc_buf;
    logic [PEND_W-1:0]   enc_pend;
    logic [BYTE_W-1:0]   flush_byte;
    logic [BUF_W-1:0]    flush_buf;

    assign clen     = a_hit_reg ? rd_len : '0;
    assign acc      = (ACC_W'(pend_bits_reg) << clen) | ACC_W'(rd_word);
    assign total    = TOT_W'(pend_cnt_reg) + TOT_W'(clen);
    assign nbytes   = CNT_W'(total >> 3);
    assign rem      = total[PCNT_W-1:0];
    // whole bytes, earliest bit at the top of the buffer
    assign acc_hi   = acc >> rem;
    assign enc_buf  = BUF_W'(acc_hi) << {CNT_W'(MAX_RES) - nbytes, 3'b000};
    assign enc_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);

    assign flush_byte = BYTE_W'(pend_bits_reg) << (4'd8 - {1'b0, pend_cnt_reg});
    assign flush_buf  = BUF_W'(flush_byte) << (BUF_W - BYTE_W);

    // buffer takes a new run once its last byte leaves
    assign buf_free = (out_cnt_reg == '0) || ((out_cnt_reg == CNT_W'(1)) && out_ready);
    assign b_fire   = a_vld_reg && buf_free;

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_buf_next   = out_buf_reg;
        out_cnt_next   = out_cnt_reg;
        out_pad_next   = out_pad_reg;

        if (out_valid && out_ready)
        begin
            out_buf_next = out_buf_reg << BYTE_W;
            out_cnt_next = out_cnt_reg - CNT_W'(1);
        end

        if (b_fire)
        begin
            case (a_op_reg)
                hcbp_pkg::OP_ENCODE:
                begin
                    if (clen != '0)
                    begin
                        out_buf_next   = enc_buf;
                        out_cnt_next   = nbytes;
                        out_pad_next   = 1'b0;
                        pend_bits_next = enc_pend;
                        pend_cnt_next  = rem;
                    end
                end
                hcbp_pkg::OP_FLUSH:
                begin
                    if (pend_cnt_reg != '0)
                    begin
                        out_buf_next   = flush_buf;
                        out_cnt_next   = CNT_W'(1);
                        out_pad_next   = 1'b1;
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                    end
                end
                default:
                begin
                    // load already done at accept; unused opcode ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            a_vld_reg     <= a_vld_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_buf_reg <= out_buf_next;
        out_pad_reg <= out_pad_next;
    end

    // ------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------
    assign out_valid            = (out_cnt_reg != '0);
    assign out_data.packed_byte = out_buf_reg[BUF_W-1 -: BYTE_W];
    assign out_data.last_of_run = (out_cnt_reg == CNT_W'(1));
    assign out_data.padded      = out_pad_reg;

endmodule

`default_nettype wire

@@ sv/hcbp_ram.sv @@
// ============================================================================
// hcbp_ram - generic single write port, single read port RAM
// Read data is registered; it holds while no read is enabled.
// ============================================================================
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/hcbp_checker.sv @@
// ============================================================================
// hcbp_sva - port-level assertions for the Huffman code bit packer
// Bound to the top level; watches both channels only.
// ============================================================================
`default_nettype none

module hcbp_sva (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire hcbp_pkg::out_item_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // a flush byte is always alone in its run
    a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.padded |-> out_data.last_of_run)
        else $error("padded byte not marked last");

    // rest of a run follows without a gap
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("gap inside a byte run");

    // bytes after the first of a run come from an encode
    a_run_nopad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> !out_data.padded)
        else $error("padded byte inside an encode run");

    // with no byte waiting the input side is open
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output is idle");

endmodule

bind huffman_code_bit_packer hcbp_sva u_hcbp_sva (.*);

`default_nettype wire
